// File: design/tlht_pkg.sv
// Shared constants and types for the two-level hash table.
// Used by two_level_hash_table and tlht_divider; no dependencies.
package tlht_pkg;

   localparam int KEY_W    = 31;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int SIZE_W   = 5;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd10;

   // default geometry
   localparam int FIRST_LEVEL_SLOTS_DEF = 10;
   localparam int MAX_SECOND_LEVEL_DEF  = 16;
   localparam int WAYS_PER_BUCKET_DEF   = 4;

   // quotient bits resolved per cycle in the serial divider
   localparam int DIV_STEPS = 4;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

   localparam logic [VALUE_W-1:0] NO_VALUE = '1;

   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } way_type;

endpackage

// File: design/two_level_hash_table.sv
// Two-level bucketed hash table: key-value store with insert and lookup.
// Depends on tlht_pkg and tlht_divider.
//
//   channel   dir   handshake             payload
//   req       in    req_valid/req_stall   req_mode, req_key, req_item_value
//   rsp       out   rsp_valid/rsp_stall   rsp_status, rsp_found_value
//   csr       in    csr_write_enable      csr_write_data (second_level_size)
//
// One item at a time. After the req transfer the serial divider that forms the bucket
// index runs, then one read and one write-back of the bucket row follow, and the result
// is loaded; the next req transfer can follow in the cycle after that load. A result held
// by rsp_stall keeps the next one waiting, with req_stall high, until the output register
// frees up. After reset a clearing pass writes every row (FIRST_LEVEL_SLOTS *
// MAX_SECOND_LEVEL rows, 160 by default) with req_stall held high.
// A new item may be taken while a result still waits on rsp_stall.
module two_level_hash_table #(
   parameter int FIRST_LEVEL_SLOTS = tlht_pkg::FIRST_LEVEL_SLOTS_DEF,
   parameter int MAX_SECOND_LEVEL  = tlht_pkg::MAX_SECOND_LEVEL_DEF,
   parameter int WAYS_PER_BUCKET   = tlht_pkg::WAYS_PER_BUCKET_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_mode,
   input  logic [tlht_pkg::KEY_W-1:0]   req_key,
   input  logic [tlht_pkg::VALUE_W-1:0] req_item_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [tlht_pkg::STATUS_W-1:0] rsp_status,
   output logic [tlht_pkg::VALUE_W-1:0]  rsp_found_value,
   input  logic                       csr_write_enable,
   input  logic [tlht_pkg::SIZE_W-1:0]  csr_write_data
);
   import tlht_pkg::*;

   localparam int ROWS   = FIRST_LEVEL_SLOTS * MAX_SECOND_LEVEL;
   localparam int ROW_W  = $clog2(ROWS);
   localparam int SEFF_W = $clog2(MAX_SECOND_LEVEL + 1);
   localparam int CMP_W  = (SEFF_W > SIZE_W) ? SEFF_W : SIZE_W;
   localparam int DEN1_W = $clog2(ROWS + 1);

   // reciprocal of FIRST_LEVEL_SLOTS, exact for every DEN1_W-bit remainder
   localparam int RECIP_SH = DEN1_W + $clog2(FIRST_LEVEL_SLOTS);
   localparam int RECIP_W  = DEN1_W + 2;
   localparam int PROD_W   = DEN1_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((1 << RECIP_SH) + FIRST_LEVEL_SLOTS - 1) / FIRST_LEVEL_SLOTS);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_DIV1  = 3'd2;
   localparam logic [2:0] S_READ  = 3'd4;
   localparam logic [2:0] S_WRITE = 3'd5;
   localparam logic [2:0] S_RESP  = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [ROW_W-1:0]    clr_cnt_ff, clr_cnt_in;
   logic [SIZE_W-1:0]   size_ff, size_in;

   logic                mode_ff, mode_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [VALUE_W-1:0]  val_ff, val_in;
   logic [ROW_W-1:0]    row_ff, row_in;

   logic [STATUS_W-1:0] pend_status_ff, pend_status_in;
   logic [VALUE_W-1:0]  pend_value_ff, pend_value_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;

   way_type [WAYS_PER_BUCKET-1:0] bucket_mem [ROWS];
   way_type [WAYS_PER_BUCKET-1:0] rd_row_ff;
   way_type [WAYS_PER_BUCKET-1:0] wr_row;
   logic                          mem_we;
   logic [ROW_W-1:0]              mem_waddr;

   logic [CMP_W-1:0]    size_wide;
   logic [SEFF_W-1:0]   size_eff;
   logic [DEN1_W-1:0]   den1;

   logic                accept;
   logic                div1_start, div1_done;
   logic [KEY_W-1:0]    div1_quot;
   logic [DEN1_W-1:0]   div1_rem;

   logic [PROD_W-1:0]   slot_prod;
   logic [ROW_W-1:0]    bucket_idx;
   logic [ROW_W-1:0]    slot_idx;
   logic [ROW_W-1:0]    row_next;

   logic                op_write;
   logic [STATUS_W-1:0] op_status;
   logic [VALUE_W-1:0]  op_value;

   // out-of-range sizes clamp to 1..MAX_SECOND_LEVEL
   always_comb begin
      size_wide = CMP_W'(size_ff);
      if (size_wide == '0) begin
         size_eff = SEFF_W'(1);
      end else if (size_wide > CMP_W'(MAX_SECOND_LEVEL)) begin
         size_eff = SEFF_W'(MAX_SECOND_LEVEL);
      end else begin
         size_eff = SEFF_W'(size_wide);
      end
      den1 = DEN1_W'(size_eff * FIRST_LEVEL_SLOTS);
   end

   assign accept     = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign div1_start = accept;

   // key mod (slots * size) gives slot and bucket in one number
   tlht_divider #(
      .NUM_W (KEY_W),
      .DEN_W (DEN1_W)
   ) u_div_key (
      .clock  (clock),
      .reset  (reset),
      .start  (div1_start),
      .numer  (req_key),
      .denom  (den1),
      .done   (div1_done),
      .quot   (div1_quot),
      .remain (div1_rem)
   );

   // split that remainder into bucket (quotient) and slot (remainder) by a reciprocal multiply
   always_comb begin
      slot_prod  = PROD_W'(div1_rem) * PROD_W'(RECIP);
      bucket_idx = ROW_W'(slot_prod >> RECIP_SH);
      slot_idx   = ROW_W'(div1_rem - DEN1_W'(bucket_idx * FIRST_LEVEL_SLOTS));
      row_next   = ROW_W'(slot_idx * MAX_SECOND_LEVEL + bucket_idx);
   end

   // bucket compare and merge on the row just read
   always_comb begin
      logic taken;
      wr_row    = rd_row_ff;
      op_write  = 1'b0;
      op_status = (mode_ff == MODE_INSERT) ? ST_FULL : ST_NOT_FOUND;
      op_value  = NO_VALUE;
      taken     = 1'b0;
      for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
         if (!taken && rd_row_ff[w].valid && (rd_row_ff[w].key == key_ff)) begin
            taken     = 1'b1;
            op_status = ST_OK;
            if (mode_ff == MODE_INSERT) begin
               wr_row[w].value = val_ff;
               op_write        = 1'b1;
            end else begin
               op_value = rd_row_ff[w].value;
            end
         end
      end
      if (mode_ff == MODE_INSERT) begin
         for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
            if (!taken && !rd_row_ff[w].valid) begin
               taken           = 1'b1;
               op_status       = ST_OK;
               wr_row[w].valid = 1'b1;
               wr_row[w].key   = key_ff;
               wr_row[w].value = val_ff;
               op_write        = 1'b1;
            end
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      clr_cnt_in     = clr_cnt_ff;
      size_in        = csr_write_enable ? csr_write_data : size_ff;
      mode_in        = mode_ff;
      key_in         = key_ff;
      val_in         = val_ff;
      row_in         = row_ff;
      pend_status_in = pend_status_ff;
      pend_value_in  = pend_value_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_value_in   = rsp_value_ff;
      mem_we         = 1'b0;
      mem_waddr      = row_ff;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + ROW_W'(1);
            if (clr_cnt_ff == ROW_W'(ROWS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               mode_in  = req_mode;
               key_in   = req_key;
               val_in   = req_item_value;
               state_in = S_DIV1;
            end
         end
         S_DIV1: begin
            if (div1_done) begin
               row_in   = row_next;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_WRITE;
         end
         S_WRITE: begin
            mem_we         = op_write;
            pend_status_in = op_status;
            pend_value_in  = op_value;
            state_in       = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_value_in  = pend_value_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         size_ff      <= SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      key_ff         <= key_in;
      val_ff         <= val_in;
      row_ff         <= row_in;
      pend_status_ff <= pend_status_in;
      pend_value_ff  <= pend_value_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_value_ff   <= rsp_value_in;
   end

   // clearing pass writes zero rows; otherwise write-back of the merged row
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bucket_mem[mem_waddr] <= (state_ff == S_CLEAR) ? '0 : wr_row;
      end
      rd_row_ff <= bucket_mem[row_ff];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_value_ff;

endmodule

// File: design/tlht_divider.sv
// Serial restoring divider: quotient and remainder, DIV_STEPS bits per cycle.
// Depends on tlht_pkg.
module tlht_divider #(
   parameter int NUM_W = 31,
   parameter int DEN_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot,
   output logic [DEN_W-1:0] remain
);
   import tlht_pkg::*;

   localparam int STEPS  = DIV_STEPS;
   localparam int CYCLES = (NUM_W + STEPS - 1) / STEPS;
   localparam int PAD_W  = CYCLES * STEPS;
   localparam int CNT_W  = $clog2(CYCLES + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PAD_W-1:0] shift_ff, shift_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;

   logic [PAD_W-1:0] step_shift;
   logic [DEN_W-1:0] step_rem;

   // shift register holds remaining numerator bits on top, quotient fills from bottom
   always_comb begin
      logic [DEN_W:0] trial;
      step_shift = shift_ff;
      step_rem   = rem_ff;
      for (int i = 0; i < STEPS; i++) begin
         trial      = {step_rem, step_shift[PAD_W-1]};
         step_shift = {step_shift[PAD_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            step_rem      = DEN_W'(trial - {1'b0, den_ff});
            step_shift[0] = 1'b1;
         end else begin
            step_rem = trial[DEN_W-1:0];
         end
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_W'(CYCLES);
         shift_in = PAD_W'(numer);
         rem_in   = '0;
         den_in   = denom;
      end else if (busy_ff) begin
         shift_in = step_shift;
         rem_in   = step_rem;
         cnt_in   = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
   end

   assign done   = done_ff;
   assign quot   = shift_ff[NUM_W-1:0];
   assign remain = rem_ff;

endmodule
